FILE: rtl/core/pes_ts_pkg.sv
`timescale 1ns / 1ps

package pes_ts_pkg;

   localparam int PAYLOAD_BYTES = 184;
   localparam int TS_BYTES      = PAYLOAD_BYTES + 4;
   localparam int TS_WORDS      = TS_BYTES / 4;
   localparam int LANE_DEPTH    = PAYLOAD_BYTES / 4;
   localparam int LANE_ADDR_W   = 6;
   localparam int WORD_IDX_W    = 6;
   localparam int PID_W         = 13;
   localparam int CSR_ADDR_W    = 3;

   localparam logic [CSR_ADDR_W-1:0] ADDR_PACKET_ID = 3'd0;

   localparam logic [7:0] SYNC_BYTE        = 8'h47;
   localparam logic [7:0] START_FLAG       = 8'h40;
   localparam logic [7:0] HDR_PAYLOAD_ONLY = 8'h10;
   localparam logic [7:0] HDR_ADAPT        = 8'h30;
   localparam logic [7:0] CC_MASK          = 8'h0f;
   localparam logic [7:0] FILL_LAST_INDEX  = 8'd183;
   localparam logic [7:0] ADAPT_MAX_LEN    = 8'd183;
   localparam logic [7:0] STUFF_BYTE       = 8'hff;
   localparam logic [7:0] FLAGS_BYTE       = 8'h00;

   typedef struct packed {
      logic [7:0] pes_byte;
      logic       pes_last;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] ts_word;
      logic        word_last;
   } rsp_payload_type;

   typedef enum logic [0:0] {
      ST_FILL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  write_byte;
      logic                  trigger;
      logic                  issue;
      logic [WORD_IDX_W-1:0] word_index;
   } dp_cmd_type;

   typedef struct packed {
      logic fill_at_end;
      logic can_issue;
   } dp_status_type;

endpackage

FILE: rtl/core/pes_to_ts_packetizer.sv
`timescale 1ns / 1ps
// On the beat that completes a packet the controller enters ST_EMIT; each word read then
// passes the lane read and s1 registers into the output register. One byte per cycle is
// taken while filling; input stalls while the 47 words go out, and output stalls hold them.
// The 184-byte store is four byte-wide lane memories, one word of payload read per cycle unless stalled.
// Reset (synchronous, active high) clears the fill count, continuity counter and PID,
// sets the unit-start flag; the payload store is not cleared.

module pes_to_ts_packetizer
   import pes_ts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [PID_W-1:0] packet_id;
   dp_cmd_type       cmd;
   dp_status_type    status;

   pes_ts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .packet_id (packet_id)
   );

   pes_ts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .pes_last  (req_payload.pes_last),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pes_ts_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .packet_id   (packet_id),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/core/pes_ts_csr.sv
`timescale 1ns / 1ps

module pes_ts_csr
   import pes_ts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output logic [PID_W-1:0]      packet_id
);

   logic [PID_W-1:0] pid_ff;
   logic [PID_W-1:0] pid_in;

   always_comb begin
      pid_in = pid_ff;
      if (psel && penable && pwrite && (paddr == ADDR_PACKET_ID)) begin
         pid_in = pwdata[PID_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pid_ff <= '0;
      end else begin
         pid_ff <= pid_in;
      end
   end

   assign prdata    = (paddr == ADDR_PACKET_ID) ? {{(32-PID_W){1'b0}}, pid_ff} : 32'd0;
   assign pready    = 1'b1;
   assign packet_id = pid_ff;

endmodule

FILE: rtl/core/pes_ts_ctrl.sv
`timescale 1ns / 1ps

module pes_ts_ctrl
   import pes_ts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          pes_last,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type             state_ff;
   state_type             state_in;
   logic [WORD_IDX_W-1:0] word_ff;
   logic [WORD_IDX_W-1:0] word_in;
   logic                  accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         word_ff  <= '0;
      end else begin
         state_ff <= state_in;
         word_ff  <= word_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      word_in        = word_ff;
      req_stall      = 1'b1;
      accept         = 1'b0;
      cmd.write_byte = 1'b0;
      cmd.trigger    = 1'b0;
      cmd.issue      = 1'b0;
      cmd.word_index = word_ff;
      unique case (state_ff)
         ST_FILL: begin
            req_stall      = 1'b0;
            accept         = req_valid;
            cmd.write_byte = accept;
            cmd.trigger    = accept && (pes_last || status.fill_at_end);
            word_in        = '0;
            if (cmd.trigger) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.issue = status.can_issue;
            if (cmd.issue) begin
               if (word_ff == WORD_IDX_W'(TS_WORDS - 1)) begin
                  word_in  = '0;
                  state_in = ST_FILL;
               end else begin
                  word_in = word_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   a_fill_word_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILL |-> word_ff == '0)
      else $error("word counter not cleared while filling");

   a_issue_in_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> state_ff == ST_EMIT && word_ff < WORD_IDX_W'(TS_WORDS))
      else $error("word read issued outside packet emission");

   a_trigger_emits: assert property (@(posedge clock) disable iff (reset)
      cmd.trigger |=> state_ff == ST_EMIT && word_ff == '0)
      else $error("packet trigger did not start emission");

endmodule

FILE: rtl/core/pes_ts_dp.sv
`timescale 1ns / 1ps

module pes_ts_dp
   import pes_ts_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  req_payload_type req_payload,
   input  logic [PID_W-1:0] packet_id,
   input  dp_cmd_type      cmd,
   output dp_status_type   status,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic [7:0]       fill_ff;
   logic [3:0]       cc_ff;
   logic             start_ff;
   logic             pk_full_ff;
   logic [7:0]       pk_len_ff;
   logic [PID_W-1:0] pk_pid_ff;
   logic [3:0]       pk_cc_ff;
   logic             pk_start_ff;

   logic                   advance;
   logic [7:0]             base;
   logic [7:0]             rest;
   logic [3:0][7:0]        byte_const;
   logic [3:0]             byte_pay;
   logic [3:0][1:0]        byte_lane;
   logic [3:0][LANE_ADDR_W-1:0] lane_addr;
   logic [3:0][7:0]        lane_rd;

   logic                   s1_valid_ff;
   logic                   s1_last_ff;
   logic [3:0][7:0]        s1_const_ff;
   logic [3:0]             s1_pay_ff;
   logic [3:0][1:0]        s1_lane_ff;

   logic                   out_valid_ff;
   logic [31:0]            out_word_ff;
   logic                   out_last_ff;
   logic [31:0]            out_word_in;

   assign advance            = !out_valid_ff || !rsp_stall;
   assign status.can_issue   = advance;
   assign status.fill_at_end = (fill_ff == FILL_LAST_INDEX);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         cc_ff    <= '0;
         start_ff <= 1'b1;
      end else begin
         if (cmd.trigger) begin
            fill_ff  <= '0;
            cc_ff    <= cc_ff + 1'b1;
            start_ff <= req_payload.pes_last;
         end else if (cmd.write_byte) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.trigger) begin
         pk_full_ff  <= status.fill_at_end;
         pk_len_ff   <= fill_ff + 1'b1;
         pk_pid_ff   <= packet_id;
         pk_cc_ff    <= cc_ff;
         pk_start_ff <= start_ff;
      end
   end

   always_comb begin
      logic [7:0] b;
      logic [7:0] s;
      logic [1:0] jm;
      base = pk_full_ff ? 8'd4 : 8'(TS_BYTES) - pk_len_ff;
      rest = ADAPT_MAX_LEN - pk_len_ff;
      for (int j = 0; j < 4; j++) begin
         b            = {cmd.word_index, 2'(j)};
         s            = b - base;
         byte_lane[j] = s[1:0];
         byte_pay[j]  = 1'b0;
         byte_const[j] = STUFF_BYTE;
         if (b == 8'd0) begin
            byte_const[j] = SYNC_BYTE;
         end else if (b == 8'd1) begin
            byte_const[j] = {3'b000, pk_pid_ff[PID_W-1:8]} | (pk_start_ff ? START_FLAG : 8'h00);
         end else if (b == 8'd2) begin
            byte_const[j] = pk_pid_ff[7:0];
         end else if (b == 8'd3) begin
            byte_const[j] = (pk_full_ff ? HDR_PAYLOAD_ONLY : HDR_ADAPT) | ({4'h0, pk_cc_ff} & CC_MASK);
         end else if (pk_full_ff || b >= base) begin
            byte_pay[j] = 1'b1;
         end else if (b == 8'd4) begin
            byte_const[j] = rest;
         end else if (b == 8'd5) begin
            byte_const[j] = FLAGS_BYTE;
         end
      end
      for (int m = 0; m < 4; m++) begin
         jm = 2'(m) + base[1:0];
         s  = {cmd.word_index, jm} - base;
         lane_addr[m] = (s[7:2] < LANE_ADDR_W'(LANE_DEPTH)) ? s[7:2] : '0;
      end
   end

   for (genvar m = 0; m < 4; m++) begin : g_lane
      logic [7:0] mem [LANE_DEPTH];
      logic [7:0] rd_ff;

      always_ff @(posedge clock) begin
         if (cmd.write_byte && (fill_ff[1:0] == 2'(m))) begin
            mem[fill_ff[7:2]] <= req_payload.pes_byte;
         end
         if (advance) begin
            rd_ff <= mem[lane_addr[m]];
         end
      end

      assign lane_rd[m] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= cmd.issue;
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_last_ff  <= (cmd.word_index == WORD_IDX_W'(TS_WORDS - 1));
         s1_const_ff <= byte_const;
         s1_pay_ff   <= byte_pay;
         s1_lane_ff  <= byte_lane;
         out_word_ff <= out_word_in;
         out_last_ff <= s1_last_ff;
      end
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         out_word_in[31-8*j -: 8] = s1_pay_ff[j] ? lane_rd[s1_lane_ff[j]] : s1_const_ff[j];
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_payload.ts_word   = out_word_ff;
   assign rsp_payload.word_last = out_last_ff;

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_LAST_INDEX)
      else $error("fill count beyond the payload store");

   a_trigger_clears_fill: assert property (@(posedge clock) disable iff (reset)
      cmd.trigger |=> fill_ff == '0)
      else $error("fill count not cleared after packet trigger");

   a_no_write_while_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !cmd.write_byte)
      else $error("payload store written during emission");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import pes_ts_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   pes_to_ts_packetizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   logic [7:0]       unit_bytes [0:PAYLOAD_BYTES-1];
   logic [7:0]       pkt_bytes [0:TS_BYTES-1];
   int               fill_cnt = 0;
   logic [3:0]       cc_next = '0;
   logic             start_due = 1'b1;
   logic [PID_W-1:0] pid_model = '0;
   rsp_payload_type  ts_expected [$];
   int               fail_count = 0;
   bit               idle_on = 1'b1;
   int               stall_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic void note_mismatch(input string text);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s", $time, text);
      end
   endfunction

   function automatic void open_packet(input logic [7:0] kind);
      pkt_bytes[0] = SYNC_BYTE;
      pkt_bytes[1] = {3'b000, pid_model[12:8]} | (start_due ? START_FLAG : 8'h00);
      pkt_bytes[2] = pid_model[7:0];
      pkt_bytes[3] = kind | ({4'h0, cc_next} & CC_MASK);
      cc_next++;
      start_due = 1'b0;
   endfunction

   function automatic void queue_packet();
      rsp_payload_type word;
      for (int w = 0; w < TS_WORDS; w++) begin
         word.ts_word = {pkt_bytes[4*w], pkt_bytes[4*w+1], pkt_bytes[4*w+2], pkt_bytes[4*w+3]};
         word.word_last = (w == TS_WORDS - 1);
         ts_expected.push_back(word);
      end
   endfunction

   function automatic void predict_packets(input req_payload_type beat);
      int len;
      int rest;
      if (fill_cnt >= PAYLOAD_BYTES) begin
         fill_cnt = 0;
      end
      unit_bytes[fill_cnt] = beat.pes_byte;
      fill_cnt++;
      if (fill_cnt == PAYLOAD_BYTES) begin
         open_packet(HDR_PAYLOAD_ONLY);
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            pkt_bytes[4+i] = unit_bytes[i];
         end
         fill_cnt = 0;
         if (beat.pes_last) begin
            start_due = 1'b1;
         end
         queue_packet();
      end else if (beat.pes_last) begin
         len = fill_cnt;
         rest = int'(ADAPT_MAX_LEN) - len;
         open_packet(HDR_ADAPT);
         pkt_bytes[4] = rest[7:0];
         if (rest > 0) begin
            pkt_bytes[5] = FLAGS_BYTE;
         end
         for (int i = 1; i < rest; i++) begin
            pkt_bytes[5+i] = STUFF_BYTE;
         end
         for (int i = 0; i < len; i++) begin
            pkt_bytes[5+rest+i] = unit_bytes[i];
         end
         fill_cnt = 0;
         start_due = 1'b1;
         queue_packet();
      end
   endfunction

   function automatic void check_word(input rsp_payload_type got);
      rsp_payload_type want;
      if (ts_expected.size() == 0) begin
         note_mismatch($sformatf("unexpected word %08h last %0b", got.ts_word, got.word_last));
         return;
      end
      want = ts_expected.pop_front();
      if (got.ts_word !== want.ts_word) begin
         note_mismatch($sformatf("ts_word expected %08h actual %08h",
                                 want.ts_word, got.ts_word));
      end
      if (got.word_last !== want.word_last) begin
         note_mismatch($sformatf("word_last expected %0b actual %0b",
                                 want.word_last, got.word_last));
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            check_word(rsp_payload);
         end
         if (req_valid && !req_stall) begin
            predict_packets(req_payload);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || !idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      req_payload_type beat;
      beat.pes_byte = value;
      beat.pes_last = last;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_unit(input int len, input bit closed = 1'b1);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), closed && (i == len - 1));
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ts_expected.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_packet_id(input logic [PID_W-1:0] value);
      logic [31:0] readback;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_PACKET_ID;
      csr_pwdata <= {19'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      pid_model = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== {19'd0, value}) begin
         note_mismatch($sformatf("packet_id readback expected %08h actual %08h",
                                 {19'd0, value}, readback));
      end
   endtask

   task automatic test_field_extremes();
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7f, 1'b1);
      for (int i = 0; i < 7; i++) begin
         send_byte(8'h01 << i, i == 6);
      end
      for (int i = 0; i < 7; i++) begin
         send_byte(~(8'h01 << i), i == 6);
      end
      drain_results();
   endtask

   task automatic test_pid_extremes();
      program_packet_id(13'h1fff);
      send_unit(3);
      send_unit(1);
      drain_results();
      program_packet_id(13'h0000);
      send_unit(2);
      drain_results();
      program_packet_id(13'h0aaa);
      send_unit(4);
      drain_results();
   endtask

   task automatic test_pid_mid_unit();
      program_packet_id(13'h1555);
      send_unit(12, 1'b0);
      drain_results();
      program_packet_id(13'h0123);
      send_unit(8);
      drain_results();
   endtask

   task automatic test_chunk_boundaries();
      program_packet_id(13'($urandom_range(0, 8191)));
      send_unit(185);
      drain_results();
   endtask

   task automatic test_counter_wrap();
      for (int i = 0; i < 18; i++) begin
         send_unit(1);
      end
      drain_results();
   endtask

   task automatic test_random_units(input int item_goal);
      int sent;
      int len;
      int pick;
      program_packet_id(13'($urandom_range(0, 8191)));
      sent = 0;
      while (sent < item_goal) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            len = $urandom_range(1, 16);
         end else begin
            len = $urandom_range(17, 40);
         end
         send_unit(len);
         sent += len;
      end
      drain_results();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_field_extremes();
      test_pid_extremes();
      test_pid_mid_unit();
      test_chunk_boundaries();
      test_counter_wrap();
      for (int phase = 0; phase < 4; phase++) begin
         idle_on = (phase != 2);
         test_random_units(20);
      end
      idle_on = 1'b0;
      test_random_units(20);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && ts_expected.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: pes_to_ts_packetizer.f
rtl/core/pes_ts_pkg.sv
rtl/core/pes_ts_csr.sv
rtl/core/pes_ts_ctrl.sv
rtl/core/pes_ts_dp.sv
rtl/core/pes_to_ts_packetizer.sv
test/tb_top.sv
